/* src/nnfs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-neighbor frame scaler package
// Shared widths, register indexes, reset values, word types and the RGB444
// to RGB565 widening function.
// ----------------------------------------------------------------------------
package nnfs_pkg;

    // Field widths fixed by the word formats.
    localparam int CFG_W     = 9;
    localparam int COORD_W   = 8;
    localparam int DST_W     = 9;
    localparam int PIX_W     = 16;
    localparam int STEP_W    = 25;
    localparam int CFG_IDX_W = 3;
    localparam int LIN_W     = 2 * COORD_W + 1;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_SRC_WIDTH  = 256;
    localparam int DEF_MAX_SRC_HEIGHT = 256;
    localparam int DEF_FRAC_BITS      = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd4;

    // Request types and pixel formats.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_READ   = 1'b1;
    localparam logic FMT_RGB565 = 1'b0;
    localparam logic FMT_RGB444 = 1'b1;

    // Register reset values.
    localparam int RST_SRC_WIDTH  = 160;
    localparam int RST_SRC_HEIGHT = 144;
    localparam int RST_DST_WIDTH  = 240;
    localparam int RST_DST_HEIGHT = 216;

    // Request word: a source pixel write or a scaled pixel read.
    typedef struct packed {
        logic               req_type;
        logic [COORD_W-1:0] src_col;
        logic [COORD_W-1:0] src_row;
        logic [PIX_W-1:0]   pixel_in;
        logic [DST_W-1:0]   dst_col;
        logic [DST_W-1:0]   dst_row;
    } t_req_word;

    // Response word: the sampled pixel and where it came from.
    typedef struct packed {
        logic [PIX_W-1:0]   pixel_out;
        logic [COORD_W-1:0] picked_col;
        logic [COORD_W-1:0] picked_row;
    } t_rsp_word;

    // Configuration write word.
    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     wr_data;
    } t_cfg_word;

    // Widen 4-bit channels in bits 11..0 to RGB565 by repeating top bits.
    function automatic logic [PIX_W-1:0] widen_rgb444(input logic [PIX_W-1:0] pix);
        logic [3:0] red;
        logic [3:0] grn;
        logic [3:0] blu;
        red = pix[11:8];
        grn = pix[7:4];
        blu = pix[3:0];
        return {red, red[3], grn, grn[3:2], blu, blu[3]};
    endfunction

endpackage
`default_nettype wire

/* src/nnfs_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-neighbor frame scaler channel interfaces
// Valid/ready channels for request words, response words and register writes.
// ----------------------------------------------------------------------------

// Request channel.
interface nnfs_req_if import nnfs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_req_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel.
interface nnfs_rsp_if import nnfs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_rsp_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Register write channel.
interface nnfs_cfg_if import nnfs_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cfg_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/nearest_neighbor_frame_scaler_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-neighbor frame scaler core
// Stores a source frame and returns nearest-neighbor samples of a scaled frame.
//
//   Channel  Dir  Word        Meaning
//   i_req    in   t_req_word  pixel write into the frame, or scaled pixel read
//   o_rsp    out  t_rsp_word  sampled pixel plus the source column and row
//   i_cfg    in   t_cfg_word  register write (sizes, pixel format)
//
// One request word is taken per cycle unless the output stalls or the steps
// are being recomputed; a read returns its word through a six-stage pipeline
// (latch, clamp, multiply, scale and clamp, frame read, format). Writes
// retire at the frame stage. A size register write recomputes both steps on
// one shared restoring divider, one quotient bit a cycle, and i_req is held
// off until it is done. Reset is synchronous; the frame contents are not cleared.
// Each stage moves when the next stage is empty or moving, so a stalled
// response word holds while earlier stages keep filling.
// ----------------------------------------------------------------------------
module nearest_neighbor_frame_scaler_core import nnfs_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT,
    parameter int FRAC_BITS      = DEF_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nnfs_req_if.sink    i_req,
    nnfs_rsp_if.source  o_rsp,
    nnfs_cfg_if.sink    i_cfg
);

    localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W  = CFG_W + FRAC_BITS;
    localparam int CNT_W  = $clog2(NUM_W);
    localparam int PROD_W = DST_W + STEP_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;

    localparam logic [STEP_W-1:0] X_STEP_RST =
        STEP_W'((RST_SRC_WIDTH * (2 ** FRAC_BITS)) / RST_DST_WIDTH);
    localparam logic [STEP_W-1:0] Y_STEP_RST =
        STEP_W'((RST_SRC_HEIGHT * (2 ** FRAC_BITS)) / RST_DST_HEIGHT);
    localparam logic [CFG_W-1:0] MAX_W_V = CFG_W'(MAX_SRC_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_V = CFG_W'(MAX_SRC_HEIGHT);

    // Step sequencer states.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_DIV_X = 2'd2;
    localparam logic [1:0] ST_DIV_Y = 2'd3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_src_w;
    logic [CFG_W-1:0] r_src_h;
    logic [CFG_W-1:0] r_dst_w;
    logic [CFG_W-1:0] r_dst_h;
    logic             r_fmt;
    logic             w_cfg_acc;
    logic             w_size_wr;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid && i_cfg.ready;
    assign w_size_wr   = w_cfg_acc && (i_cfg.data.reg_idx == REG_SRC_WIDTH ||
                                       i_cfg.data.reg_idx == REG_SRC_HEIGHT ||
                                       i_cfg.data.reg_idx == REG_DST_WIDTH ||
                                       i_cfg.data.reg_idx == REG_DST_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(RST_SRC_WIDTH);
            r_src_h <= CFG_W'(RST_SRC_HEIGHT);
            r_dst_w <= CFG_W'(RST_DST_WIDTH);
            r_dst_h <= CFG_W'(RST_DST_HEIGHT);
            r_fmt   <= FMT_RGB565;
        end else if (w_cfg_acc) begin
            case (i_cfg.data.reg_idx)
                REG_SRC_WIDTH:    r_src_w <= i_cfg.data.wr_data;
                REG_SRC_HEIGHT:   r_src_h <= i_cfg.data.wr_data;
                REG_DST_WIDTH:    r_dst_w <= i_cfg.data.wr_data;
                REG_DST_HEIGHT:   r_dst_h <= i_cfg.data.wr_data;
                REG_PIXEL_FORMAT: r_fmt   <= i_cfg.data.wr_data[0];
                default: begin
                end
            endcase
        end
    end

    // Effective sizes: a zero destination counts as one, the source size
    // is forced into one up to the frame maximum.
    logic [CFG_W-1:0] w_dx_nz;
    logic [CFG_W-1:0] w_dy_nz;
    logic [CFG_W-1:0] w_dx_m1;
    logic [CFG_W-1:0] w_dy_m1;
    logic [CFG_W-1:0] w_sx_m1;
    logic [CFG_W-1:0] w_sy_m1;

    assign w_dx_nz = (r_dst_w == '0) ? CFG_W'(1) : r_dst_w;
    assign w_dy_nz = (r_dst_h == '0) ? CFG_W'(1) : r_dst_h;
    assign w_dx_m1 = w_dx_nz - CFG_W'(1);
    assign w_dy_m1 = w_dy_nz - CFG_W'(1);
    assign w_sx_m1 = (r_src_w == '0) ? '0 :
                     ((r_src_w > MAX_W_V) ? MAX_W_V : r_src_w) - CFG_W'(1);
    assign w_sy_m1 = (r_src_h == '0) ? '0 :
                     ((r_src_h > MAX_H_V) ? MAX_H_V : r_src_h) - CFG_W'(1);

    // ------------------------------------------------------------------
    // Step divider: (src << FRAC_BITS) / dst, x first, then y
    // ------------------------------------------------------------------
    logic [1:0]        r_state;
    logic [STEP_W-1:0] r_x_step;
    logic [STEP_W-1:0] r_y_step;
    logic [NUM_W-1:0]  r_div_q;
    logic [CFG_W-1:0]  r_div_rem;
    logic [CFG_W-1:0]  r_div_d;
    logic [CNT_W-1:0]  r_div_cnt;
    logic [CFG_W:0]    w_trial;
    logic [CFG_W:0]    w_diff;
    logic              w_ge;
    logic [CFG_W-1:0]  n_div_rem;
    logic [NUM_W-1:0]  n_div_q;
    logic              w_idle;

    assign w_trial   = {r_div_rem, r_div_q[NUM_W-1]};
    assign w_ge      = w_trial >= {1'b0, r_div_d};
    assign w_diff    = w_trial - {1'b0, r_div_d};
    assign n_div_rem = w_ge ? w_diff[CFG_W-1:0] : w_trial[CFG_W-1:0];
    assign n_div_q   = {r_div_q[NUM_W-2:0], w_ge};
    assign w_idle    = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_x_step <= X_STEP_RST;
            r_y_step <= Y_STEP_RST;
        end else if (w_size_wr) begin
            // A new size write restarts the computation.
            r_state <= ST_LOAD;
        end else begin
            case (r_state)
                ST_IDLE: begin
                end
                ST_LOAD: begin
                    r_div_q   <= {r_src_w, {FRAC_BITS{1'b0}}};
                    r_div_rem <= '0;
                    r_div_d   <= w_dx_nz;
                    r_div_cnt <= CNT_W'(NUM_W - 1);
                    r_state   <= ST_DIV_X;
                end
                ST_DIV_X: begin
                    if (r_div_cnt == '0) begin
                        r_x_step  <= STEP_W'(n_div_q);
                        r_div_q   <= {r_src_h, {FRAC_BITS{1'b0}}};
                        r_div_rem <= '0;
                        r_div_d   <= w_dy_nz;
                        r_div_cnt <= CNT_W'(NUM_W - 1);
                        r_state   <= ST_DIV_Y;
                    end else begin
                        r_div_q   <= n_div_q;
                        r_div_rem <= n_div_rem;
                        r_div_cnt <= r_div_cnt - CNT_W'(1);
                    end
                end
                ST_DIV_Y: begin
                    if (r_div_cnt == '0) begin
                        r_y_step <= STEP_W'(n_div_q);
                        r_state  <= ST_IDLE;
                    end else begin
                        r_div_q   <= n_div_q;
                        r_div_rem <= n_div_rem;
                        r_div_cnt <= r_div_cnt - CNT_W'(1);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic r_s1_v;
    logic r_s2_v;
    logic r_s3_v;
    logic r_s4_v;
    logic r_s5_v;
    logic r_s6_v;
    logic w_rdy1;
    logic w_rdy2;
    logic w_rdy3;
    logic w_rdy4;
    logic w_rdy5;
    logic w_rdy6;
    logic w_req_acc;

    assign w_rdy6    = !r_s6_v || o_rsp.ready;
    assign w_rdy5    = !r_s5_v || w_rdy6;
    assign w_rdy4    = !r_s4_v || w_rdy5;
    assign w_rdy3    = !r_s3_v || w_rdy4;
    assign w_rdy2    = !r_s2_v || w_rdy3;
    assign w_rdy1    = !r_s1_v || w_rdy2;
    assign w_req_acc = i_req.valid && i_req.ready;

    assign i_req.ready = w_rdy1 && w_idle;

    // Stage payload registers.
    t_req_word          r_s1_word;
    logic               r_s2_type;
    logic               r_s2_wok;
    logic [COORD_W-1:0] r_s2_col;
    logic [COORD_W-1:0] r_s2_row;
    logic [PIX_W-1:0]   r_s2_pix;
    logic [DST_W-1:0]   r_s2_cx;
    logic [DST_W-1:0]   r_s2_cy;
    logic               r_s3_type;
    logic               r_s3_wok;
    logic [COORD_W-1:0] r_s3_col;
    logic [COORD_W-1:0] r_s3_row;
    logic [PIX_W-1:0]   r_s3_pix;
    logic [PROD_W-1:0]  r_s3_px;
    logic [PROD_W-1:0]  r_s3_py;
    logic               r_s4_type;
    logic               r_s4_wok;
    logic [COORD_W-1:0] r_s4_sc;
    logic [COORD_W-1:0] r_s4_sr;
    logic [PIX_W-1:0]   r_s4_pix;
    logic [COORD_W-1:0] r_s5_sc;
    logic [COORD_W-1:0] r_s5_sr;
    logic [PIX_W-1:0]   r_s5_rd;
    t_rsp_word          r_s6_word;

    // Valid bits travel with the words; writes leave after the frame stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_s1_v <= w_req_acc;
            end
            if (w_rdy2) begin
                r_s2_v <= r_s1_v;
            end
            if (w_rdy3) begin
                r_s3_v <= r_s2_v;
            end
            if (w_rdy4) begin
                r_s4_v <= r_s3_v;
            end
            if (w_rdy5) begin
                r_s5_v <= r_s4_v && (r_s4_type == REQ_READ);
            end
            if (w_rdy6) begin
                r_s6_v <= r_s5_v;
            end
        end
    end

    // Stage 2 inputs: clamp destination coordinates, range-check writes.
    logic [DST_W-1:0] w_cx;
    logic [DST_W-1:0] w_cy;
    logic             w_wok;

    assign w_cx  = (r_s1_word.dst_col > w_dx_m1) ? w_dx_m1 : r_s1_word.dst_col;
    assign w_cy  = (r_s1_word.dst_row > w_dy_m1) ? w_dy_m1 : r_s1_word.dst_row;
    assign w_wok = ({1'b0, r_s1_word.src_col} < MAX_W_V) &&
                   ({1'b0, r_s1_word.src_row} < MAX_H_V);

    // Stage 4 inputs: for reads, drop the fraction and clamp to the source size; writes keep their coordinates.
    logic [SH_W-1:0]    w_shx;
    logic [SH_W-1:0]    w_shy;
    logic [COORD_W-1:0] w_sc;
    logic [COORD_W-1:0] w_sr;

    assign w_shx = r_s3_px[PROD_W-1:FRAC_BITS];
    assign w_shy = r_s3_py[PROD_W-1:FRAC_BITS];
    assign w_sc  = (r_s3_type == REQ_WRITE) ? r_s3_col :
                   (w_shx > SH_W'(w_sx_m1)) ? w_sx_m1[COORD_W-1:0] : w_shx[COORD_W-1:0];
    assign w_sr  = (r_s3_type == REQ_WRITE) ? r_s3_row :
                   (w_shy > SH_W'(w_sy_m1)) ? w_sy_m1[COORD_W-1:0] : w_shy[COORD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_s1_word <= i_req.data;
        end
        if (w_rdy2) begin
            r_s2_type <= r_s1_word.req_type;
            r_s2_wok  <= w_wok;
            r_s2_col  <= r_s1_word.src_col;
            r_s2_row  <= r_s1_word.src_row;
            r_s2_pix  <= r_s1_word.pixel_in;
            r_s2_cx   <= w_cx;
            r_s2_cy   <= w_cy;
        end
        if (w_rdy3) begin
            r_s3_type <= r_s2_type;
            r_s3_wok  <= r_s2_wok;
            r_s3_col  <= r_s2_col;
            r_s3_row  <= r_s2_row;
            r_s3_pix  <= r_s2_pix;
            r_s3_px   <= PROD_W'(r_s2_cx) * PROD_W'(r_x_step);
            r_s3_py   <= PROD_W'(r_s2_cy) * PROD_W'(r_y_step);
        end
        if (w_rdy4) begin
            r_s4_type <= r_s3_type;
            r_s4_wok  <= r_s3_wok;
            r_s4_sc   <= w_sc;
            r_s4_sr   <= w_sr;
            r_s4_pix  <= r_s3_pix;
        end
        if (w_rdy5) begin
            r_s5_sc <= r_s4_sc;
            r_s5_sr <= r_s4_sr;
        end
        if (w_rdy6) begin
            r_s6_word.pixel_out  <= (r_fmt == FMT_RGB444) ? widen_rgb444(r_s5_rd)
                                                          : r_s5_rd;
            r_s6_word.picked_col <= r_s5_sc;
            r_s6_word.picked_row <= r_s5_sr;
        end
    end

    // ------------------------------------------------------------------
    // Frame store: one write or one registered read per cycle
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]  r_frame_store [DEPTH];
    logic [LIN_W-1:0]  w_lin;
    logic [ADDR_W-1:0] w_addr;
    logic              w_mem_we;

    assign w_lin    = LIN_W'(r_s4_sr) * LIN_W'(MAX_SRC_WIDTH) + LIN_W'(r_s4_sc);
    assign w_addr   = w_lin[ADDR_W-1:0];
    assign w_mem_we = r_s4_v && w_rdy5 && (r_s4_type == REQ_WRITE) && r_s4_wok;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_frame_store[w_addr] <= r_s4_pix;
        end
        if (w_rdy5) begin
            r_s5_rd <= r_frame_store[w_addr];
        end
    end

    // Response channel comes straight from the last stage.
    assign o_rsp.valid = r_s6_v;
    assign o_rsp.data  = r_s6_word;

endmodule
`default_nettype wire

/* src/nnfs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Nearest-neighbor frame scaler port checker
// Watches the core's channels for response ordering, step-update hold-off
// and sampled coordinates inside the source frame.
// ----------------------------------------------------------------------------
module nnfs_checker import nnfs_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = DEF_MAX_SRC_WIDTH,
    parameter int MAX_SRC_HEIGHT = DEF_MAX_SRC_HEIGHT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    input  logic                 i_req_ready,
    input  logic                 i_req_type,
    input  logic                 i_rsp_valid,
    input  logic                 i_rsp_ready,
    input  logic [PIX_W-1:0]     i_pixel_out,
    input  logic [COORD_W-1:0]   i_picked_col,
    input  logic [COORD_W-1:0]   i_picked_row,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam logic [CFG_W-1:0] MAX_W_V = CFG_W'(MAX_SRC_WIDTH);
    localparam logic [CFG_W-1:0] MAX_H_V = CFG_W'(MAX_SRC_HEIGHT);

    logic [3:0]       r_outstanding;
    logic [CFG_W-1:0] r_src_w;
    logic [CFG_W-1:0] r_src_h;
    logic             w_rd_acc;
    logic             w_rsp_acc;
    logic             w_cfg_acc;
    logic             w_size_wr;
    logic [CFG_W-1:0] w_col_lim;
    logic [CFG_W-1:0] w_row_lim;

    assign w_rd_acc  = i_req_valid && i_req_ready && (i_req_type == REQ_READ);
    assign w_rsp_acc = i_rsp_valid && i_rsp_ready;
    assign w_cfg_acc = i_cfg_valid && i_cfg_ready;
    assign w_size_wr = w_cfg_acc && (i_cfg_idx == REG_SRC_WIDTH ||
                                     i_cfg_idx == REG_SRC_HEIGHT ||
                                     i_cfg_idx == REG_DST_WIDTH ||
                                     i_cfg_idx == REG_DST_HEIGHT);

    // Reads taken but not yet answered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            r_outstanding <= r_outstanding + {3'b0, w_rd_acc} - {3'b0, w_rsp_acc};
        end
    end

    // Shadow of the source size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= CFG_W'(RST_SRC_WIDTH);
            r_src_h <= CFG_W'(RST_SRC_HEIGHT);
        end else if (w_cfg_acc) begin
            if (i_cfg_idx == REG_SRC_WIDTH) begin
                r_src_w <= i_cfg_data;
            end
            if (i_cfg_idx == REG_SRC_HEIGHT) begin
                r_src_h <= i_cfg_data;
            end
        end
    end

    assign w_col_lim = (r_src_w == '0) ? '0 :
                       ((r_src_w > MAX_W_V) ? MAX_W_V : r_src_w) - CFG_W'(1);
    assign w_row_lim = (r_src_h == '0) ? '0 :
                       ((r_src_h > MAX_H_V) ? MAX_H_V : r_src_h) - CFG_W'(1);

    // A stalled response word holds its value.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            i_rsp_valid && $stable(i_pixel_out) && $stable(i_picked_col) &&
            $stable(i_picked_row))
        else $error("response word changed while stalled");

    // Every response answers an earlier read.
    a_rsp_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> r_outstanding != 4'd0)
        else $error("response word without a pending read");

    // Requests are held off once a size write starts the step recomputation.
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_size_wr |=> !i_req_ready)
        else $error("request taken right after a size write");

    // The sampled pixel lies inside the source frame.
    a_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> ({1'b0, i_picked_col} <= w_col_lim) &&
                        ({1'b0, i_picked_row} <= w_row_lim))
        else $error("sampled coordinate outside the source frame");

endmodule

bind nearest_neighbor_frame_scaler_core nnfs_checker #(
    .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
    .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT)
) u_nnfs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_req_type   (i_req.data.req_type),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_pixel_out  (o_rsp.data.pixel_out),
    .i_picked_col (o_rsp.data.picked_col),
    .i_picked_row (o_rsp.data.picked_row),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_idx    (i_cfg.data.reg_idx),
    .i_cfg_data   (i_cfg.data.wr_data)
);
`default_nettype wire
